FILE: rtl/mcg_pkg.sv
// ----------------------------------------------------------------------------
// mcg_pkg
// Types and constants shared by the match consistency graph core.
// ----------------------------------------------------------------------------
`default_nettype none

package mcg_pkg;

  localparam int COORD_W    = 14;
  localparam int LEN_W      = 15;
  localparam int THR_W      = 15;
  localparam int SQ_W       = 2 * COORD_W;
  localparam int RT_W       = 31;
  localparam int ROW_W      = 9;
  localparam int CNT_W      = 10;
  localparam int CHUNK_W    = 3;
  localparam int LANE_W     = 6;
  localparam int CHUNK_BITS = 64;
  localparam int ROW_LIMIT  = 512;
  localparam logic [THR_W-1:0] THR_RESET = THR_W'(16);

  typedef struct packed {
    logic               first_of_set;
    logic [COORD_W-1:0] key_x;
    logic [COORD_W-1:0] key_y;
    logic [COORD_W-1:0] cur_x;
    logic [COORD_W-1:0] cur_y;
  } in_t;

  typedef struct packed {
    logic [ROW_W-1:0]      row_index;
    logic [CHUNK_W-1:0]    chunk_index;
    logic [CHUNK_BITS-1:0] adj_mask;
    logic                  last_chunk;
    logic                  overflow;
  } out_t;

  typedef struct packed {
    logic load_in;
    logic sq_en;
    logic sum_en;
    logic root_step;
    logic rd_en;
    logic load_out;
    logic ovf_out;
    logic chunk_inc;
    logic store_wr;
  } cmd_t;

  typedef struct packed {
    logic overflow;
    logic last_chunk;
    logic out_free;
  } status_t;

endpackage

`default_nettype wire

FILE: rtl/mcg_ram.sv
// ----------------------------------------------------------------------------
// mcg_ram
// Simple dual-port RAM, one write and one read port, registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module mcg_ram #(
  parameter int WIDTH = 15,
  parameter int DEPTH = 8,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

FILE: rtl/mcg_ctrl.sv
// ----------------------------------------------------------------------------
// mcg_ctrl
// Sequencer: input capture, squaring, sum, root iterations, chunk compare loop, overflow result.
// ----------------------------------------------------------------------------
`default_nettype none

module mcg_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  mcg_pkg::status_t status,
  output mcg_pkg::cmd_t    cmd
);

  import mcg_pkg::*;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_SQ   = 3'd1;
  localparam logic [2:0] S_SUM  = 3'd2;
  localparam logic [2:0] S_ROOT = 3'd3;
  localparam logic [2:0] S_RD   = 3'd4;
  localparam logic [2:0] S_CMP  = 3'd5;
  localparam logic [2:0] S_OVF  = 3'd6;

  localparam logic [2:0] ITER_LAST = 3'd7;

  logic [2:0] state;
  logic [2:0] state_next;
  logic [2:0] iter;

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    unique case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load_in = 1'b1;
          state_next  = status.overflow ? S_OVF : S_SQ;
        end
      end
      S_SQ: begin
        cmd.sq_en  = 1'b1;
        state_next = S_SUM;
      end
      S_SUM: begin
        cmd.sum_en = 1'b1;
        state_next = S_ROOT;
      end
      S_ROOT: begin
        cmd.root_step = 1'b1;
        if (iter == ITER_LAST) begin
          state_next = S_RD;
        end
      end
      S_RD: begin
        cmd.rd_en  = 1'b1;
        state_next = S_CMP;
      end
      S_CMP: begin
        if (status.out_free) begin
          cmd.load_out = 1'b1;
          if (status.last_chunk) begin
            cmd.store_wr = 1'b1;
            state_next   = S_IDLE;
          end else begin
            cmd.chunk_inc = 1'b1;
            state_next    = S_RD;
          end
        end
      end
      S_OVF: begin
        if (status.out_free) begin
          cmd.ovf_out = 1'b1;
          state_next  = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      iter  <= '0;
    end else begin
      state <= state_next;
      if (cmd.root_step) begin
        iter <= iter + 3'd1;
      end else begin
        iter <= '0;
      end
    end
  end

  assert property (@(posedge clk) disable iff (rst)
    in_ready |-> state == S_IDLE)
    else $error("ready outside idle");

  assert property (@(posedge clk) disable iff (rst)
    cmd.store_wr |-> cmd.load_out && status.last_chunk)
    else $error("store without last chunk");

  assert property (@(posedge clk) disable iff (rst)
    (state == S_ROOT && iter == ITER_LAST) |=> state == S_RD)
    else $error("root loop did not end");

endmodule

`default_nettype wire

FILE: rtl/mcg_datapath.sv
// ----------------------------------------------------------------------------
// mcg_datapath
// Displacement length by iterative root, banked length store, chunk compare.
// ----------------------------------------------------------------------------
`default_nettype none

module mcg_datapath #(
  parameter int CAPACITY = 512
) (
  input  logic                        clk,
  input  logic                        rst,
  input  mcg_pkg::cmd_t               cmd,
  output mcg_pkg::status_t            status,
  input  logic                        cfg_we,
  input  logic [mcg_pkg::THR_W-1:0]   cfg_wdata,
  input  mcg_pkg::in_t                in_data,
  output logic                        out_valid,
  input  logic                        out_ready,
  output mcg_pkg::out_t               out_data
);

  import mcg_pkg::*;

  localparam int BANK_DEPTH = (CAPACITY + CHUNK_BITS - 1) / CHUNK_BITS;
  localparam int BANK_AW    = (BANK_DEPTH > 1) ? $clog2(BANK_DEPTH) : 1;
  localparam logic [CNT_W-1:0] CAP_CNT = CNT_W'(CAPACITY);

  logic [THR_W-1:0]   thr;
  logic [CNT_W-1:0]   count;
  logic [COORD_W-1:0] dx, dy;
  logic [SQ_W-1:0]    sq_x, sq_y;
  logic [RT_W-1:0]    rem, root, rbit;
  logic [RT_W-1:0]    s1, rem1, root1, b2, s2, rem2, root2;
  logic [CHUNK_W-1:0] chunk;
  logic [ROW_W-1:0]   row, row_m1;
  logic [CHUNK_W-1:0] last_idx;
  logic [LEN_W-1:0]   len;
  logic [LEN_W-1:0]   rd [CHUNK_BITS];
  logic [CHUNK_BITS-1:0] mask;

  always_ff @(posedge clk) begin
    if (rst) begin
      thr <= THR_RESET;
    end else if (cfg_we) begin
      thr <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (cmd.load_in && in_data.first_of_set) begin
      count <= '0;
    end else if (cmd.store_wr) begin
      count <= count + CNT_W'(1);
    end
  end

  assign status.overflow = !in_data.first_of_set && (count >= CAP_CNT);

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      dx <= (in_data.key_x >= in_data.cur_x) ? in_data.key_x - in_data.cur_x
                                              : in_data.cur_x - in_data.key_x;
      dy <= (in_data.key_y >= in_data.cur_y) ? in_data.key_y - in_data.cur_y
                                              : in_data.cur_y - in_data.key_y;
    end
    if (cmd.sq_en) begin
      sq_x <= dx * dx;
      sq_y <= dy * dy;
    end
  end

  // two root digits per cycle
  always_comb begin
    s1 = root + rbit;
    if (rem >= s1) begin
      rem1  = rem - s1;
      root1 = (root >> 1) + rbit;
    end else begin
      rem1  = rem;
      root1 = root >> 1;
    end
    b2 = rbit >> 2;
    s2 = root1 + b2;
    if (rem1 >= s2) begin
      rem2  = rem1 - s2;
      root2 = (root1 >> 1) + b2;
    end else begin
      rem2  = rem1;
      root2 = root1 >> 1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.sum_en) begin
      rem  <= RT_W'(sq_x) + RT_W'(sq_y);
      root <= '0;
      rbit <= RT_W'(1) << (RT_W - 1);
    end else if (cmd.root_step) begin
      rem  <= rem2;
      root <= root2;
      rbit <= rbit >> 4;
    end
  end

  assign len = root[LEN_W-1:0];

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      chunk <= '0;
    end else if (cmd.chunk_inc) begin
      chunk <= chunk + CHUNK_W'(1);
    end
  end

  assign row      = count[ROW_W-1:0];
  assign row_m1   = row - ROW_W'(1);
  assign last_idx = (row == '0) ? '0 : row_m1[ROW_W-1 -: CHUNK_W];
  assign status.last_chunk = (chunk == last_idx);

  for (genvar k = 0; k < CHUNK_BITS; k++) begin : g_bank
    mcg_ram #(
      .WIDTH(LEN_W),
      .DEPTH(BANK_DEPTH)
    ) u_bank (
      .clk  (clk),
      .we   (cmd.store_wr && (row[LANE_W-1:0] == LANE_W'(k))),
      .waddr(row[LANE_W +: BANK_AW]),
      .wdata(len),
      .re   (cmd.rd_en),
      .raddr(chunk[BANK_AW-1:0]),
      .rdata(rd[k])
    );
  end

  always_comb begin
    for (int k = 0; k < CHUNK_BITS; k++) begin
      logic [ROW_W-1:0] idx;
      logic [LEN_W-1:0] diff;
      idx     = {chunk, LANE_W'(k)};
      diff    = (len >= rd[k]) ? len - rd[k] : rd[k] - len;
      mask[k] = (idx < row) && (diff < thr);
    end
  end

  assign status.out_free = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load_out || cmd.ovf_out) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_data.row_index   <= row;
      out_data.chunk_index <= chunk;
      out_data.adj_mask    <= mask;
      out_data.last_chunk  <= status.last_chunk;
      out_data.overflow    <= 1'b0;
    end else if (cmd.ovf_out) begin
      out_data.row_index   <= '0;
      out_data.chunk_index <= '0;
      out_data.adj_mask    <= '0;
      out_data.last_chunk  <= 1'b1;
      out_data.overflow    <= 1'b1;
    end
  end

  assert property (@(posedge clk) disable iff (rst)
    cmd.ovf_out |=> out_valid && out_data.overflow && out_data.last_chunk
                    && out_data.adj_mask == '0)
    else $error("overflow item malformed");

  assert property (@(posedge clk) disable iff (rst)
    count <= CAP_CNT)
    else $error("match count beyond capacity");

  assert property (@(posedge clk) disable iff (rst)
    cmd.store_wr |=> count == $past(count) + CNT_W'(1))
    else $error("count not advanced on store");

endmodule

`default_nettype wire

FILE: rtl/pairwise_match_consistency_graph_core.sv
// Flow: an accepted item is captured, squared and summed, runs the two-digit
//   root loop, then takes one bank read plus compare per chunk; an overflow
//   item gives only a flagged result. A new match is accepted only once the
//   previous match's last chunk (chunks = 1..8) is in the output register.
// Reset: threshold 16, match count 0; length store contents stay undefined.
// ----------------------------------------------------------------------------
// pairwise_match_consistency_graph_core
// Match displacement lengths and lower-triangular consistency rows.
// ----------------------------------------------------------------------------
`default_nettype none

module pairwise_match_consistency_graph_core #(
  parameter int MAX_MATCHES = 512
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_we,
  input  logic [mcg_pkg::THR_W-1:0] cfg_wdata,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  mcg_pkg::in_t              in_data,
  output logic                      out_valid,
  input  logic                      out_ready,
  output mcg_pkg::out_t             out_data
);

  import mcg_pkg::*;

  localparam int CAPACITY = (MAX_MATCHES > ROW_LIMIT) ? ROW_LIMIT : MAX_MATCHES;

  cmd_t    cmd;
  status_t status;

  mcg_ctrl u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .status  (status),
    .cmd     (cmd)
  );

  mcg_datapath #(
    .CAPACITY(CAPACITY)
  ) u_datapath (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .status   (status),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

endmodule

`default_nettype wire
